// ----- design/pidl_pkg.sv -----
// Package for the positional insert/delete list unit.
// Holds field widths, operation and status codes, and the sequencer state type.
package pidl_pkg;

  localparam int MODE_W  = 2;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_APPEND = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MOVE,
    S_PLACE,
    S_RWAIT,
    S_REPLY
  } state_t;

endpackage

// ----- design/pidl_if.sv -----
// Valid/ready channel interfaces for the list unit: request and result.
// Depends on pidl_pkg for field widths.
interface pidl_in_if import pidl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] item_value;

  modport source (output valid, mode, position, item_value, input ready);
  modport sink   (input valid, mode, position, item_value, output ready);
endinterface

interface pidl_out_if import pidl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [COUNT_W-1:0]       entry_count;
  logic [STAT_W-1:0]        status;

  modport source (output valid, read_value, entry_count, status, input ready);
  modport sink   (input valid, read_value, entry_count, status, output ready);
endinterface

// ----- design/positional_insert_delete_list_unit.sv -----
// Top level of the positional insert/delete list unit.
// Depends on pidl_pkg and the channel interfaces in pidl_if.sv.
//
// Ordered list of up to CAPACITY signed words held in a single-port-write,
// single-port-read memory with registered read data. One request is worked
// at a time; in_ch.ready is high only while the sequencer is idle. Insert
// and erase move entries one by one through the memory, each move a read
// (S_FETCH) followed by a write (S_MOVE). The result sits in an output
// register until taken; a new request is accepted as soon as the previous
// result has been loaded there.
module positional_insert_delete_list_unit import pidl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pidl_in_if.sink     in_ch,
  pidl_out_if.source  out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [XW-1:0]     pos_r, pos_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  status_t           st_r, st_nxt;
  logic [WORD_W-1:0] rd_r, rd_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  status_t           out_st_r, out_st_nxt;

  logic [XW-1:0]     in_pos_x;
  logic [XW-1:0]     count_x;
  logic [XW-1:0]     idx_x;
  logic              full;
  logic              accept;

  assign in_pos_x = XW'(in_ch.position);
  assign count_x  = XW'(count_r);
  assign idx_x    = XW'(idx_r);
  assign full     = (count_r == CW'(CAPACITY));
  assign accept   = in_ch.valid && in_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_value_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.status      = out_st_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r      <= mode_nxt;
    pos_r       <= pos_nxt;
    word_r      <= word_nxt;
    idx_r       <= idx_nxt;
    st_r        <= st_nxt;
    rd_r        <= rd_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_st_r    <= out_st_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    st_nxt        = st_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[AW-1:0];
    mem_wdata     = rdata_r;
    mem_raddr     = pos_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        mem_raddr = in_pos_x[AW-1:0];
        if (accept) begin
          mode_nxt = mode_t'(in_ch.mode);
          pos_nxt  = in_pos_x;
          word_nxt = in_ch.item_value;
          rd_nxt   = '0;
          st_nxt   = ST_DONE;
          case (mode_t'(in_ch.mode))
            MODE_READ: begin
              if (in_pos_x < count_x) begin
                state_nxt = S_RWAIT;
              end else begin
                st_nxt    = ST_RANGE;
                state_nxt = S_REPLY;
              end
            end
            MODE_INSERT: begin
              idx_nxt = count_r;
              if (full) begin
                st_nxt    = ST_FULL;
                state_nxt = S_REPLY;
              end else if (in_pos_x > count_x) begin
                st_nxt    = ST_RANGE;
                state_nxt = S_REPLY;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            MODE_ERASE: begin
              idx_nxt = in_pos_x[CW-1:0];
              if (in_pos_x >= count_x) begin
                st_nxt    = ST_RANGE;
                state_nxt = S_REPLY;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            default: begin
              pos_nxt = count_x;
              if (full) begin
                st_nxt    = ST_FULL;
                state_nxt = S_REPLY;
              end else begin
                state_nxt = S_PLACE;
              end
            end
          endcase
        end
      end
      S_FETCH: begin
        if (mode_r == MODE_INSERT) begin
          mem_raddr = AW'(idx_r - 1'b1);
          if (idx_x > pos_r) begin
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_PLACE;
          end
        end else begin
          mem_raddr = AW'(idx_r + 1'b1);
          if ((idx_x + 1'b1) < count_x) begin
            state_nxt = S_MOVE;
          end else begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_REPLY;
          end
        end
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = rdata_r;
        idx_nxt   = (mode_r == MODE_INSERT) ? idx_r - 1'b1 : idx_r + 1'b1;
        state_nxt = S_FETCH;
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = word_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_REPLY;
      end
      S_RWAIT: begin
        rd_nxt    = rdata_r;
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_r;
          out_count_nxt = count_x[COUNT_W-1:0];
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ((count_r == $past(count_r) + 1'b1) || (count_r == $past(count_r) - 1'b1)))
    else $error("entry count changed by more than one");

  a_move_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> (idx_r < CW'(CAPACITY)))
    else $error("shift index outside the store");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && (out_st_r == ST_FULL)) |-> full)
    else $error("full status while list not full");

  a_idle_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPLY && (!out_valid_r || out_ch.ready)) |=>
      (state_r == S_IDLE && out_valid_r))
    else $error("result not loaded on reply");

endmodule

// ----- dv/pidl_list_checker.sv -----
// Checker for the positional insert/delete list unit: watches both channels, keeps
// its own copy of the list, predicts each result and compares it with the DUT output.
// Depends on pidl_pkg and the channel interfaces in pidl_if.sv.
module pidl_list_checker import pidl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pidl_in_if          in_ch,
  pidl_out_if         out_ch,
  output int unsigned mismatch_count,
  output int unsigned results_awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [COUNT_W-1:0]       entry_count;
    status_t                  status;
  } list_reply_t;

  logic signed [WORD_W-1:0] list_words [CAPACITY];
  int unsigned              list_len;
  list_reply_t              reply_queue [$];
  int unsigned              fails;

  function automatic list_reply_t apply_request(mode_t m, logic [POS_W-1:0] p,
                                                logic signed [WORD_W-1:0] w);
    list_reply_t r;
    int unsigned pos;
    r = '{read_value: '0, entry_count: '0, status: ST_DONE};
    pos = p;
    case (m)
      MODE_READ: begin
        if (pos < list_len) r.read_value = list_words[pos];
        else r.status = ST_RANGE;
      end
      MODE_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = w;
          list_len++;
        end
      end
      MODE_ERASE: begin
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = w;
          list_len++;
        end
      end
    endcase
    r.entry_count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void flag_mismatch(string what);
    if (fails < 10) $display("%0t ns: mismatch: %s", $realtime, what);
    fails++;
  endfunction

  always @(posedge clk) begin
    list_reply_t want;
    list_reply_t got;
    if (!rst_n) begin
      list_len = 0;
      fails    = 0;
      reply_queue.delete();
    end else begin
      // results leave before requests enter: a result at this edge is always older
      if (out_ch.valid && out_ch.ready) begin
        got = '{read_value: out_ch.read_value, entry_count: out_ch.entry_count,
                status: status_t'(out_ch.status)};
        if (reply_queue.size() == 0) begin
          flag_mismatch($sformatf("unexpected result read_value=%0d count=%0d status=%0d",
                                  got.read_value, got.entry_count, got.status));
        end else begin
          want = reply_queue.pop_front();
          if (got.read_value !== want.read_value || got.entry_count !== want.entry_count ||
              got.status !== want.status)
            flag_mismatch($sformatf(
              "expected read_value=%0d count=%0d status=%0d, got %0d/%0d/%0d",
              want.read_value, want.entry_count, want.status,
              got.read_value, got.entry_count, got.status));
        end
      end
      if (in_ch.valid && in_ch.ready)
        reply_queue.insert(reply_queue.size(),
                           apply_request(mode_t'(in_ch.mode), in_ch.position,
                                         in_ch.item_value));
    end
    mismatch_count  <= fails;
    results_awaited <= reply_queue.size();
  end

endmodule

// ----- dv/tb_positional_insert_delete_list_unit.sv -----
// Testbench top for the positional insert/delete list unit: clock, reset, request
// stimulus with sender gaps and receiver stalls, and the final verdict.
// Depends on pidl_pkg, pidl_if.sv, the DUT and dv/pidl_list_checker.sv.
module tb_positional_insert_delete_list_unit import pidl_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned results_awaited;
  int unsigned snd_gap_pct;
  int unsigned rcv_stall_pct;

  pidl_in_if  in_ch ();
  pidl_out_if out_ch ();

  positional_insert_delete_list_unit #(.CAPACITY(CAPACITY)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pidl_list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .results_awaited (results_awaited)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // valid stays high across back-to-back requests; it only drops for a gap
  task automatic send_request(mode_t m, logic [POS_W-1:0] p, logic [WORD_W-1:0] w);
    if ($urandom_range(0, 99) < snd_gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_gap_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.position   <= p;
    in_ch.item_value <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
  endtask

  // bias: 0 grows the list, 1 shrinks it, 2 mixes evenly
  task automatic random_request(int unsigned bias);
    int unsigned      roll;
    mode_t            m;
    logic [POS_W-1:0] p;
    logic [WORD_W-1:0] w;
    roll = $urandom_range(0, 99);
    case (bias)
      0:       m = roll < 35 ? MODE_APPEND : roll < 70 ? MODE_INSERT :
                   roll < 90 ? MODE_READ : MODE_ERASE;
      1:       m = roll < 55 ? MODE_ERASE : roll < 80 ? MODE_READ :
                   roll < 90 ? MODE_INSERT : MODE_APPEND;
      default: m = mode_t'(roll % 4);
    endcase
    p = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(0, 31))
                                    : POS_W'($urandom_range(0, CAPACITY));
    case ($urandom_range(0, 19))
      0:       w = 32'h8000_0000;
      1:       w = 32'h7FFF_FFFF;
      2:       w = '1;
      3:       w = '0;
      default: w = $urandom();
    endcase
    send_request(m, p, w);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  initial begin
    snd_gap_pct      = 0;
    rcv_stall_pct    = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_READ;
    in_ch.position   <= '0;
    in_ch.item_value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: read, erase and an insert past the end are out of range; then the list fills
    send_request(MODE_READ,   5'd0,  32'h0);
    send_request(MODE_ERASE,  5'd0,  32'h0);
    send_request(MODE_INSERT, 5'd1,  32'h1234_5678);
    send_request(MODE_INSERT, 5'd0,  32'h8000_0000);
    send_request(MODE_APPEND, 5'd31, 32'h7FFF_FFFF);
    send_request(MODE_INSERT, 5'd1,  32'hFFFF_FFFF);
    send_request(MODE_READ,   5'd1,  32'h0);
    send_request(MODE_READ,   5'd3,  32'h0);
    send_request(MODE_ERASE,  5'd1,  32'h0);
    // insert at the end position
    send_request(MODE_INSERT, 5'd2,  32'h0);
    for (int k = 0; k < CAPACITY - 3; k++)
      send_request(MODE_APPEND, POS_W'($urandom_range(0, 31)), $urandom());
    // full list
    send_request(MODE_APPEND, 5'd0,  32'h5555_5555);
    send_request(MODE_INSERT, 5'd0,  32'hAAAA_AAAA);
    send_request(MODE_READ,   5'd15, 32'h0);
    send_request(MODE_ERASE,  5'd0,  32'h0);
    send_request(MODE_READ,   5'd31, 32'hFFFF_FFFF);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin snd_gap_pct = 0;  rcv_stall_pct = 0;  end
        1:       begin snd_gap_pct = 71; rcv_stall_pct = 0;  end
        2:       begin snd_gap_pct = 0;  rcv_stall_pct = 71; end
        default: begin snd_gap_pct = 21; rcv_stall_pct = 21; end
      endcase
      for (int blk = 0; blk < 9; blk++) begin
        int unsigned bias;
        bias = $urandom_range(0, 2);
        repeat (50) random_request(bias);
      end
      drain_results();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pidl_pkg.sv
design/pidl_if.sv
design/positional_insert_delete_list_unit.sv
dv/pidl_list_checker.sv
dv/tb_positional_insert_delete_list_unit.sv
